>>> rtl/core/kcore_decomposition_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the k-core decomposition core
// Implication forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef KCORE_DECOMPOSITION_CORE_ASSERT_SVH
`define KCORE_DECOMPOSITION_CORE_ASSERT_SVH

// same-cycle implication
`define KCD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("kcd port check failed");

// next-cycle implication
`define KCD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("kcd port check failed");

`endif

>>> rtl/core/kcd_pkg.sv
// ----------------------------------------------------------------------------
// kcd_pkg
// Types and constants shared by the k-core decomposition core.
// ----------------------------------------------------------------------------
`default_nettype none

package kcd_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_ENTRIES  = 8192;
    localparam int DEG_SPAN     = 1024;

    localparam int VA_W  = $clog2(MAX_VERTICES);
    localparam int VC_W  = VA_W + 1;
    localparam int EA_W  = $clog2(MAX_ENTRIES);
    localparam int EC_W  = EA_W + 1;
    localparam int DEG_W = $clog2(DEG_SPAN);
    localparam int ID_W  = 10;

    localparam logic KIND_COMPUTE = 1'b0;
    localparam logic KIND_QUERY   = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD_DEG = 2'd0,
        OP_LOAD_NB  = 2'd1,
        OP_COMPUTE  = 2'd2,
        OP_QUERY    = 2'd3
    } t_op;

    typedef struct packed {
        t_op               opcode;
        logic [DEG_W-1:0]  vertex_degree;
        logic [ID_W-1:0]   neighbor_vertex;
        logic [ID_W-1:0]   query_vertex;
    } t_in;

    typedef struct packed {
        logic              result_kind;
        logic [DEG_W-1:0]  core_number;
        logic [ID_W-1:0]   answered_vertex;
        logic              load_error;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR,
        S_CNT_RD,
        S_CNT_BIN,
        S_CNT_WR,
        S_PFX_RD,
        S_PFX_WR,
        S_PLC_RD,
        S_PLC_BIN,
        S_PLC_WR,
        S_PEEL_VAP,
        S_PEEL_CUR,
        S_PEEL_END,
        S_PEEL_ROW,
        S_ADJ_RD,
        S_ADJ_U,
        S_ADJ_CMP,
        S_SW_BIN,
        S_SW_W,
        S_SW_B,
        S_MAX_RD,
        S_MAX_ACC,
        S_DONE,
        S_QRY
    } t_state;

    typedef struct packed {
        t_state step;
        logic   accept;
    } t_cmd;

    typedef struct packed {
        logic idx_end;
        logic bin_end;
        logic row_more;
        logic nb_ok;
        logic higher;
        logic pos_ok;
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/core/kcore_decomposition_core.sv
// ----------------------------------------------------------------------------
// kcore_decomposition_core
// Core numbers of an undirected graph by bin-sort peeling.
// ----------------------------------------------------------------------------
// Usage: drive a word on i_cmd and raise start; it is taken at an edge where
// busy is low. Vertex loads append a vertex with its degree, neighbor loads
// append one adjacency entry; loads stream at one word per cycle and give no
// result. A taken query enters the query state, which registers its answer.
// A compute word walks the sequencer through bin clear (bins 0 to top, top =
// largest loaded degree), count, prefix, place, peel and maximum scan. Peel
// walks each vertex's adjacency row and lowers by one the core value of each
// loaded neighbor whose core value is higher. The answer comes in the cycle
// after the sequencer finishes. Each result shows on o_result for one cycle
// with o_strobe high; the receiver cannot stall it. Reset empties the graph
// and clears the error flag; stores need no clearing pass, since only
// written entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module kcore_decomposition_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire kcd_pkg::t_in i_cmd,
    output logic              o_strobe,
    output kcd_pkg::t_out     o_result
);

    kcd_pkg::t_cmd  cmd;
    kcd_pkg::t_stat stat;

    kcd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_cmd.opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    kcd_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_cmd),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

>>> rtl/core/kcd_ram.sv
// ----------------------------------------------------------------------------
// kcd_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/kcd_ctrl.sv
// ----------------------------------------------------------------------------
// kcd_ctrl
// Sequencer for load, bin sort, peel, maximum scan and query.
// ----------------------------------------------------------------------------
`default_nettype none

module kcd_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire kcd_pkg::t_op   i_opcode,
    input  wire kcd_pkg::t_stat i_stat,
    output kcd_pkg::t_cmd       o_cmd,
    output logic                o_busy
);

    kcd_pkg::t_state r_state;
    kcd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kcd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.step   = r_state;
        o_cmd.accept = 1'b0;
        o_busy       = (r_state != kcd_pkg::S_IDLE);
        case (r_state)
            kcd_pkg::S_IDLE: begin
                o_cmd.accept = i_start;
                if (i_start) begin
                    case (i_opcode)
                        kcd_pkg::OP_COMPUTE: n_state = kcd_pkg::S_CLR;
                        kcd_pkg::OP_QUERY:   n_state = kcd_pkg::S_QRY;
                        default:             n_state = kcd_pkg::S_IDLE;
                    endcase
                end
            end
            kcd_pkg::S_CLR:      if (i_stat.bin_end) n_state = kcd_pkg::S_CNT_RD;
            kcd_pkg::S_CNT_RD: begin
                n_state = i_stat.idx_end ? kcd_pkg::S_PFX_RD : kcd_pkg::S_CNT_BIN;
            end
            kcd_pkg::S_CNT_BIN:  n_state = kcd_pkg::S_CNT_WR;
            kcd_pkg::S_CNT_WR:   n_state = kcd_pkg::S_CNT_RD;
            kcd_pkg::S_PFX_RD:   n_state = kcd_pkg::S_PFX_WR;
            kcd_pkg::S_PFX_WR: begin
                n_state = i_stat.bin_end ? kcd_pkg::S_PLC_RD : kcd_pkg::S_PFX_RD;
            end
            kcd_pkg::S_PLC_RD: begin
                n_state = i_stat.idx_end ? kcd_pkg::S_PEEL_VAP : kcd_pkg::S_PLC_BIN;
            end
            kcd_pkg::S_PLC_BIN:  n_state = kcd_pkg::S_PLC_WR;
            kcd_pkg::S_PLC_WR:   n_state = kcd_pkg::S_PLC_RD;
            kcd_pkg::S_PEEL_VAP: begin
                n_state = i_stat.idx_end ? kcd_pkg::S_MAX_RD : kcd_pkg::S_PEEL_CUR;
            end
            kcd_pkg::S_PEEL_CUR: n_state = kcd_pkg::S_PEEL_END;
            kcd_pkg::S_PEEL_END: n_state = kcd_pkg::S_PEEL_ROW;
            kcd_pkg::S_PEEL_ROW: n_state = kcd_pkg::S_ADJ_RD;
            kcd_pkg::S_ADJ_RD: begin
                n_state = i_stat.row_more ? kcd_pkg::S_ADJ_U : kcd_pkg::S_PEEL_VAP;
            end
            kcd_pkg::S_ADJ_U: begin
                n_state = i_stat.nb_ok ? kcd_pkg::S_ADJ_CMP : kcd_pkg::S_ADJ_RD;
            end
            kcd_pkg::S_ADJ_CMP: begin
                n_state = i_stat.higher ? kcd_pkg::S_SW_BIN : kcd_pkg::S_ADJ_RD;
            end
            kcd_pkg::S_SW_BIN: begin
                n_state = i_stat.pos_ok ? kcd_pkg::S_SW_W : kcd_pkg::S_ADJ_RD;
            end
            kcd_pkg::S_SW_W:     n_state = kcd_pkg::S_SW_B;
            kcd_pkg::S_SW_B:     n_state = kcd_pkg::S_ADJ_RD;
            kcd_pkg::S_MAX_RD: begin
                n_state = i_stat.idx_end ? kcd_pkg::S_DONE : kcd_pkg::S_MAX_ACC;
            end
            kcd_pkg::S_MAX_ACC:  n_state = kcd_pkg::S_MAX_RD;
            kcd_pkg::S_DONE:     n_state = kcd_pkg::S_IDLE;
            kcd_pkg::S_QRY:      n_state = kcd_pkg::S_IDLE;
            default:             n_state = kcd_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/kcd_datapath.sv
// ----------------------------------------------------------------------------
// kcd_datapath
// Graph stores, bin tables, index counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kcd_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire kcd_pkg::t_cmd i_cmd,
    input  wire kcd_pkg::t_in  i_item,
    output kcd_pkg::t_stat     o_stat,
    output logic               o_strobe,
    output kcd_pkg::t_out      o_result
);

    localparam int VA_W  = kcd_pkg::VA_W;
    localparam int VC_W  = kcd_pkg::VC_W;
    localparam int EA_W  = kcd_pkg::EA_W;
    localparam int EC_W  = kcd_pkg::EC_W;
    localparam int DEG_W = kcd_pkg::DEG_W;
    localparam int ID_W  = kcd_pkg::ID_W;

    // persistent control state
    logic [VC_W-1:0]  r_vc;
    logic [EC_W-1:0]  r_ec;
    logic [DEG_W-1:0] r_top;
    logic             r_ovf;
    logic             r_strobe;
    kcd_pkg::t_out    r_res;

    // working registers
    logic [VC_W-1:0]  r_v;
    logic [VC_W-1:0]  r_i;
    logic [DEG_W-1:0] r_d;
    logic [VC_W-1:0]  r_start;
    logic [DEG_W-1:0] r_c;
    logic [VA_W-1:0]  r_cur;
    logic [DEG_W-1:0] r_cc;
    logic [EC_W-1:0]  r_j;
    logic [EC_W-1:0]  r_end;
    logic [ID_W-1:0]  r_u;
    logic [DEG_W-1:0] r_cu;
    logic [VA_W-1:0]  r_pu;
    logic [VC_W-1:0]  r_pw;
    logic [VA_W-1:0]  r_w;
    logic             r_swap;
    logic [DEG_W-1:0] r_best;
    logic [ID_W-1:0]  r_q;

    // memory ports
    logic             rs_we;
    logic [VA_W-1:0]  rs_wa, rs_ra;
    logic [EC_W-1:0]  rs_wd, rs_rd;
    logic             adj_we;
    logic [EA_W-1:0]  adj_wa, adj_ra;
    logic [ID_W-1:0]  adj_wd, adj_rd;
    logic             core_we;
    logic [VA_W-1:0]  core_wa, core_ra;
    logic [DEG_W-1:0] core_wd, core_rd;
    logic             fill_we;
    logic [DEG_W-1:0] fill_wa, fill_ra;
    logic [VC_W-1:0]  fill_wd, fill_rd;
    logic             bin_we;
    logic [DEG_W-1:0] bin_wa, bin_ra;
    logic [VC_W-1:0]  bin_wd, bin_rd;
    logic             pos_we;
    logic [VA_W-1:0]  pos_wa, pos_ra, pos_wd, pos_rd;
    logic             vap_we;
    logic [VA_W-1:0]  vap_wa, vap_ra, vap_wd, vap_rd;

    logic             load_deg;
    logic             load_nb;
    logic             vtx_full;
    logic             adj_full;
    logic             nb_bad;
    logic             swap_now;
    logic [VC_W-1:0]  next_cur;

    kcd_ram #(.WIDTH(EC_W), .DEPTH(kcd_pkg::MAX_VERTICES)) u_row_start (
        .i_clk(i_clk), .i_we(rs_we), .i_waddr(rs_wa), .i_wdata(rs_wd),
        .i_raddr(rs_ra), .o_rdata(rs_rd));
    kcd_ram #(.WIDTH(ID_W), .DEPTH(kcd_pkg::MAX_ENTRIES)) u_adjacency (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_wa), .i_wdata(adj_wd),
        .i_raddr(adj_ra), .o_rdata(adj_rd));
    kcd_ram #(.WIDTH(DEG_W), .DEPTH(kcd_pkg::MAX_VERTICES)) u_core (
        .i_clk(i_clk), .i_we(core_we), .i_waddr(core_wa), .i_wdata(core_wd),
        .i_raddr(core_ra), .o_rdata(core_rd));
    kcd_ram #(.WIDTH(VC_W), .DEPTH(kcd_pkg::DEG_SPAN)) u_bin_fill (
        .i_clk(i_clk), .i_we(fill_we), .i_waddr(fill_wa), .i_wdata(fill_wd),
        .i_raddr(fill_ra), .o_rdata(fill_rd));
    kcd_ram #(.WIDTH(VC_W), .DEPTH(kcd_pkg::DEG_SPAN)) u_bin_start (
        .i_clk(i_clk), .i_we(bin_we), .i_waddr(bin_wa), .i_wdata(bin_wd),
        .i_raddr(bin_ra), .o_rdata(bin_rd));
    kcd_ram #(.WIDTH(VA_W), .DEPTH(kcd_pkg::MAX_VERTICES)) u_pos (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(pos_wa), .i_wdata(pos_wd),
        .i_raddr(pos_ra), .o_rdata(pos_rd));
    kcd_ram #(.WIDTH(VA_W), .DEPTH(kcd_pkg::MAX_VERTICES)) u_vap (
        .i_clk(i_clk), .i_we(vap_we), .i_waddr(vap_wa), .i_wdata(vap_wd),
        .i_raddr(vap_ra), .o_rdata(vap_rd));

    assign load_deg = i_cmd.accept && (i_item.opcode == kcd_pkg::OP_LOAD_DEG);
    assign load_nb  = i_cmd.accept && (i_item.opcode == kcd_pkg::OP_LOAD_NB);
    assign vtx_full = (r_vc == VC_W'(kcd_pkg::MAX_VERTICES));
    assign adj_full = (r_ec == EC_W'(kcd_pkg::MAX_ENTRIES));
    assign nb_bad   = (32'(i_item.neighbor_vertex) >= kcd_pkg::MAX_VERTICES);
    assign swap_now = (VC_W'(vap_rd) < r_vc) && (vap_rd != VA_W'(r_u));
    assign next_cur = VC_W'(r_cur) + VC_W'(1);

    always_comb begin
        o_stat.idx_end  = (i_cmd.step == kcd_pkg::S_PEEL_VAP) ? (r_i == r_vc)
                                                              : (r_v == r_vc);
        o_stat.bin_end  = (r_d == r_top);
        o_stat.row_more = (r_j < r_end);
        o_stat.nb_ok    = (VC_W'(adj_rd) < r_vc);
        o_stat.higher   = (core_rd > r_cc);
        o_stat.pos_ok   = (bin_rd < r_vc) && (VC_W'(r_pu) < r_vc);
    end

    always_comb begin
        rs_we   = 1'b0; rs_wa   = '0; rs_wd   = '0; rs_ra   = '0;
        adj_we  = 1'b0; adj_wa  = '0; adj_wd  = '0; adj_ra  = '0;
        core_we = 1'b0; core_wa = '0; core_wd = '0; core_ra = '0;
        fill_we = 1'b0; fill_wa = '0; fill_wd = '0; fill_ra = '0;
        bin_we  = 1'b0; bin_wa  = '0; bin_wd  = '0; bin_ra  = '0;
        pos_we  = 1'b0; pos_wa  = '0; pos_wd  = '0; pos_ra  = '0;
        vap_we  = 1'b0; vap_wa  = '0; vap_wd  = '0; vap_ra  = '0;
        case (i_cmd.step)
            kcd_pkg::S_IDLE: begin
                core_ra = VA_W'(i_item.query_vertex);
                if (load_deg && !vtx_full) begin
                    rs_we   = 1'b1;
                    rs_wa   = r_vc[VA_W-1:0];
                    rs_wd   = r_ec;
                    core_we = 1'b1;
                    core_wa = r_vc[VA_W-1:0];
                    core_wd = i_item.vertex_degree;
                end
                if (load_nb && !adj_full && !nb_bad) begin
                    adj_we = 1'b1;
                    adj_wa = r_ec[EA_W-1:0];
                    adj_wd = i_item.neighbor_vertex;
                end
            end
            kcd_pkg::S_CLR: begin
                fill_we = 1'b1;
                fill_wa = r_d;
            end
            kcd_pkg::S_CNT_RD:  core_ra = r_v[VA_W-1:0];
            kcd_pkg::S_CNT_BIN: fill_ra = core_rd;
            kcd_pkg::S_CNT_WR: begin
                fill_we = 1'b1;
                fill_wa = r_c;
                fill_wd = fill_rd + VC_W'(1);
            end
            kcd_pkg::S_PFX_RD:  fill_ra = r_d;
            kcd_pkg::S_PFX_WR: begin
                fill_we = 1'b1;
                fill_wa = r_d;
                fill_wd = r_start;
                bin_we  = 1'b1;
                bin_wa  = r_d;
                bin_wd  = r_start;
            end
            kcd_pkg::S_PLC_RD:  core_ra = r_v[VA_W-1:0];
            kcd_pkg::S_PLC_BIN: fill_ra = core_rd;
            kcd_pkg::S_PLC_WR: begin
                fill_we = 1'b1;
                fill_wa = r_c;
                fill_wd = fill_rd + VC_W'(1);
                if (fill_rd < r_vc) begin
                    pos_we = 1'b1;
                    pos_wa = r_v[VA_W-1:0];
                    pos_wd = fill_rd[VA_W-1:0];
                    vap_we = 1'b1;
                    vap_wa = fill_rd[VA_W-1:0];
                    vap_wd = r_v[VA_W-1:0];
                end
            end
            kcd_pkg::S_PEEL_VAP: vap_ra = r_i[VA_W-1:0];
            kcd_pkg::S_PEEL_CUR: begin
                core_ra = vap_rd;
                rs_ra   = vap_rd;
            end
            kcd_pkg::S_PEEL_END: rs_ra = next_cur[VA_W-1:0];
            kcd_pkg::S_ADJ_RD:   adj_ra = r_j[EA_W-1:0];
            kcd_pkg::S_ADJ_U: begin
                core_ra = VA_W'(adj_rd);
                pos_ra  = VA_W'(adj_rd);
            end
            kcd_pkg::S_ADJ_CMP: bin_ra = core_rd;
            kcd_pkg::S_SW_BIN:  vap_ra = bin_rd[VA_W-1:0];
            kcd_pkg::S_SW_W: begin
                // advance the bin start and drop the neighbor's core value
                bin_we  = 1'b1;
                bin_wa  = r_cu;
                bin_wd  = r_pw + VC_W'(1);
                core_we = 1'b1;
                core_wa = VA_W'(r_u);
                core_wd = r_cu - DEG_W'(1);
                if (swap_now) begin
                    pos_we = 1'b1;
                    pos_wa = VA_W'(r_u);
                    pos_wd = r_pw[VA_W-1:0];
                    vap_we = 1'b1;
                    vap_wa = r_pu;
                    vap_wd = vap_rd;
                end
            end
            kcd_pkg::S_SW_B: begin
                if (r_swap) begin
                    pos_we = 1'b1;
                    pos_wa = r_w;
                    pos_wd = r_pu;
                    vap_we = 1'b1;
                    vap_wa = r_pw[VA_W-1:0];
                    vap_wd = VA_W'(r_u);
                end
            end
            kcd_pkg::S_MAX_RD: core_ra = r_v[VA_W-1:0];
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc     <= '0;
            r_ec     <= '0;
            r_top    <= '0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.step == kcd_pkg::S_DONE) || (i_cmd.step == kcd_pkg::S_QRY);
            if (load_deg) begin
                if (vtx_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_vc <= r_vc + VC_W'(1);
                    if (i_item.vertex_degree > r_top) begin
                        r_top <= i_item.vertex_degree;
                    end
                end
            end
            if (load_nb) begin
                if (adj_full || nb_bad) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_ec <= r_ec + EC_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.step)
            kcd_pkg::S_IDLE: begin
                r_q     <= i_item.query_vertex;
                r_d     <= '0;
                r_start <= '0;
            end
            kcd_pkg::S_CLR: begin
                r_d <= o_stat.bin_end ? '0 : r_d + DEG_W'(1);
                r_v <= '0;
            end
            kcd_pkg::S_CNT_BIN: r_c <= core_rd;
            kcd_pkg::S_CNT_WR:  r_v <= r_v + VC_W'(1);
            kcd_pkg::S_PFX_RD: begin
                r_v <= '0;
                r_i <= '0;
            end
            kcd_pkg::S_PFX_WR: begin
                r_start <= r_start + fill_rd;
                r_d     <= r_d + DEG_W'(1);
            end
            kcd_pkg::S_PLC_BIN: r_c <= core_rd;
            kcd_pkg::S_PLC_WR:  r_v <= r_v + VC_W'(1);
            kcd_pkg::S_PEEL_VAP: begin
                r_v    <= '0;
                r_best <= '0;
            end
            kcd_pkg::S_PEEL_CUR: begin
                r_cur <= vap_rd;
                r_i   <= r_i + VC_W'(1);
            end
            kcd_pkg::S_PEEL_END: begin
                r_cc <= core_rd;
                r_j  <= rs_rd;
            end
            kcd_pkg::S_PEEL_ROW: r_end <= (next_cur < r_vc) ? rs_rd : r_ec;
            kcd_pkg::S_ADJ_U: begin
                r_u <= adj_rd;
                r_j <= r_j + EC_W'(1);
            end
            kcd_pkg::S_ADJ_CMP: begin
                r_cu <= core_rd;
                r_pu <= pos_rd;
            end
            kcd_pkg::S_SW_BIN: r_pw <= bin_rd;
            kcd_pkg::S_SW_W: begin
                r_w    <= vap_rd;
                r_swap <= swap_now;
            end
            kcd_pkg::S_MAX_ACC: begin
                if (core_rd > r_best) begin
                    r_best <= core_rd;
                end
                r_v <= r_v + VC_W'(1);
            end
            kcd_pkg::S_DONE: begin
                r_res.result_kind     <= kcd_pkg::KIND_COMPUTE;
                r_res.core_number     <= r_best;
                r_res.answered_vertex <= '0;
                r_res.load_error      <= r_ovf;
            end
            kcd_pkg::S_QRY: begin
                r_res.result_kind     <= kcd_pkg::KIND_QUERY;
                r_res.core_number     <= (VC_W'(r_q) < r_vc) ? core_rd : '0;
                r_res.answered_vertex <= r_q;
                r_res.load_error      <= r_ovf;
            end
            default: begin
            end
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

`default_nettype wire

>>> rtl/core/kcd_checker.sv
// ----------------------------------------------------------------------------
// kcd_checker
// Port-level checks of the k-core decomposition core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kcore_decomposition_core_assert.svh"

module kcd_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire kcd_pkg::t_in  i_cmd,
    input wire logic          o_strobe,
    input wire kcd_pkg::t_out o_result
);

    logic take_load;
    logic take_query;

    assign take_load  = start && !busy && ((i_cmd.opcode == kcd_pkg::OP_LOAD_DEG) ||
                                           (i_cmd.opcode == kcd_pkg::OP_LOAD_NB));
    assign take_query = start && !busy && (i_cmd.opcode == kcd_pkg::OP_QUERY);

    `KCD_ASSERT_NEXT(a_strobe_single, o_strobe, !o_strobe)
    `KCD_ASSERT_NEXT(a_load_quiet, take_load, !busy && !o_strobe)
    `KCD_ASSERT_IMPL(a_query_answer, $past(take_query, 2), o_strobe && (o_result.result_kind == kcd_pkg::KIND_QUERY) && (o_result.answered_vertex == $past(i_cmd.query_vertex, 2)))
    `KCD_ASSERT_IMPL(a_compute_id, o_strobe && (o_result.result_kind == kcd_pkg::KIND_COMPUTE), o_result.answered_vertex == '0)

endmodule

bind kcore_decomposition_core kcd_checker u_kcd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire

>>> tb/tb_kcore_decomposition_core.sv
// ----------------------------------------------------------------------------
// tb_kcore_decomposition_core
// Self-checking bench for the k-core decomposition core: graphs are loaded
// word by word, peeled and queried; a scoreboard predicts every compute and
// query answer and checks each strobed result against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_kcore_decomposition_core;

    class core_number_tracker;
        logic [13:0]   row_first [kcd_pkg::MAX_VERTICES];
        logic [9:0]    nb_list   [kcd_pkg::MAX_ENTRIES];
        logic [9:0]    core_val  [kcd_pkg::MAX_VERTICES];
        int            bin_head  [kcd_pkg::DEG_SPAN];
        int            pos_of    [kcd_pkg::MAX_VERTICES];
        int            at_pos    [kcd_pkg::MAX_VERTICES];
        int            n_vert;
        int            n_entry;
        logic [9:0]    top_deg;
        logic          overflow;
        kcd_pkg::t_out pending_answers[$];
        int            errors;

        function new();
            n_vert = 0;
            n_entry = 0;
            top_deg = '0;
            overflow = 1'b0;
            errors = 0;
        endfunction

        function int row_stop(int v);
            if (v + 1 < n_vert) return row_first[v + 1];
            return n_entry;
        endfunction

        function logic [9:0] peel();
            int v, i, j, acc, cnt, cur, stop, u, du, pu, pw, w;
            logic [9:0] best;
            for (int d = 0; d <= top_deg; d++) bin_head[d] = 0;
            for (v = 0; v < n_vert; v++) bin_head[core_val[v]]++;
            acc = 0;
            for (int d = 0; d <= top_deg; d++) begin
                cnt = bin_head[d];
                bin_head[d] = acc;
                acc += cnt;
            end
            for (v = 0; v < n_vert; v++) begin
                if (bin_head[core_val[v]] < n_vert) begin
                    pos_of[v] = bin_head[core_val[v]];
                    at_pos[bin_head[core_val[v]]] = v;
                end
                bin_head[core_val[v]]++;
            end
            for (int d = top_deg; d > 0; d--) bin_head[d] = bin_head[d - 1];
            bin_head[0] = 0;
            for (i = 0; i < n_vert; i++) begin
                cur = at_pos[i];
                if (cur >= n_vert) continue;
                stop = row_stop(cur);
                if (stop > kcd_pkg::MAX_ENTRIES) stop = kcd_pkg::MAX_ENTRIES;
                for (j = row_first[cur]; j < stop; j++) begin
                    u = nb_list[j];
                    if (u >= n_vert) continue;
                    if (core_val[u] > core_val[cur]) begin
                        du = core_val[u];
                        pu = pos_of[u];
                        pw = bin_head[du];
                        if (pw >= n_vert || pu >= n_vert) continue;
                        w = at_pos[pw];
                        if (u != w && w < n_vert) begin
                            pos_of[u] = pw;
                            pos_of[w] = pu;
                            at_pos[pu] = w;
                            at_pos[pw] = u;
                        end
                        bin_head[du]++;
                        core_val[u] = core_val[u] - 10'd1;
                    end
                end
            end
            best = '0;
            for (v = 0; v < n_vert; v++)
                if (core_val[v] > best) best = core_val[v];
            return best;
        endfunction

        // advance the predicted graph by one accepted word
        function void note(kcd_pkg::t_in w);
            kcd_pkg::t_out r;
            r = '0;
            r.load_error = overflow;
            case (w.opcode)
                kcd_pkg::OP_LOAD_DEG: begin
                    if (n_vert >= kcd_pkg::MAX_VERTICES) begin
                        overflow = 1'b1;
                    end else begin
                        row_first[n_vert] = 14'(n_entry);
                        core_val[n_vert] = w.vertex_degree;
                        if (w.vertex_degree > top_deg) top_deg = w.vertex_degree;
                        n_vert++;
                    end
                end
                kcd_pkg::OP_LOAD_NB: begin
                    if (n_entry >= kcd_pkg::MAX_ENTRIES ||
                        w.neighbor_vertex >= kcd_pkg::MAX_VERTICES) begin
                        overflow = 1'b1;
                    end else begin
                        nb_list[n_entry] = w.neighbor_vertex;
                        n_entry++;
                    end
                end
                kcd_pkg::OP_COMPUTE: begin
                    r.result_kind = kcd_pkg::KIND_COMPUTE;
                    r.core_number = peel();
                    pending_answers.insert(pending_answers.size(), r);
                end
                default: begin
                    r.result_kind = kcd_pkg::KIND_QUERY;
                    r.answered_vertex = w.query_vertex;
                    r.core_number = (w.query_vertex < n_vert) ? core_val[w.query_vertex]
                                                              : '0;
                    pending_answers.insert(pending_answers.size(), r);
                end
            endcase
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
            errors++;
        endtask

        task check(kcd_pkg::t_out got);
            kcd_pkg::t_out want;
            if (pending_answers.size() == 0) begin
                report("unexpected word", got, 0);
                return;
            end
            want = pending_answers.pop_front();
            if (got.result_kind !== want.result_kind)
                report("result_kind", got.result_kind, want.result_kind);
            if (got.core_number !== want.core_number)
                report("core_number", got.core_number, want.core_number);
            if (got.answered_vertex !== want.answered_vertex)
                report("answered_vertex", got.answered_vertex, want.answered_vertex);
            if (got.load_error !== want.load_error)
                report("load_error", got.load_error, want.load_error);
        endtask
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    kcd_pkg::t_in  i_cmd;
    logic          o_strobe;
    kcd_pkg::t_out o_result;

    core_number_tracker sb;
    bit quiet;

    kcore_decomposition_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("tb: failure");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check(o_result);
    end

    task automatic send(kcd_pkg::t_op op, int deg, int nb, int q);
        kcd_pkg::t_in w;
        w.opcode = op;
        w.vertex_degree = 10'(deg);
        w.neighbor_vertex = 10'(nb);
        w.query_vertex = 10'(q);
        i_cmd <= w;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note(w);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // hold the sender until every answer is in
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // a large degree gets only a short row, so the core value exceeds the row
    task automatic add_vertex(int deg);
        int fan;
        fan = (deg > 8) ? 8 : deg;
        send(kcd_pkg::OP_LOAD_DEG, deg, $urandom, $urandom);
        for (int k = 0; k < fan; k++)
            send(kcd_pkg::OP_LOAD_NB, $urandom,
                 $urandom_range(0, sb.n_vert + 3) % 1024, $urandom);
    endtask

    initial begin
        int pick;
        sb = new();
        quiet = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty graph, entries ahead of any vertex, extreme degrees and ids
        send(kcd_pkg::OP_QUERY, 0, 0, 0);
        send(kcd_pkg::OP_COMPUTE, 0, 0, 0);
        send(kcd_pkg::OP_LOAD_NB, 0, 1023, 0);
        send(kcd_pkg::OP_LOAD_NB, 0, 1, 0);
        send(kcd_pkg::OP_LOAD_DEG, 1023, 0, 0);
        send(kcd_pkg::OP_LOAD_NB, 0, 1, 0);
        send(kcd_pkg::OP_LOAD_NB, 0, 2, 0);
        send(kcd_pkg::OP_LOAD_NB, 0, 1023, 0);
        send(kcd_pkg::OP_LOAD_DEG, 2, 0, 0);
        send(kcd_pkg::OP_LOAD_NB, 0, 0, 0);
        send(kcd_pkg::OP_LOAD_NB, 0, 2, 0);
        send(kcd_pkg::OP_LOAD_DEG, 0, 0, 0);
        send(kcd_pkg::OP_LOAD_DEG, 2, 0, 0);
        send(kcd_pkg::OP_LOAD_NB, 0, 0, 0);
        send(kcd_pkg::OP_LOAD_NB, 0, 1, 0);
        send(kcd_pkg::OP_COMPUTE, 0, 0, 0);
        send(kcd_pkg::OP_QUERY, 0, 0, 0);
        send(kcd_pkg::OP_QUERY, 0, 0, 1);
        send(kcd_pkg::OP_QUERY, 0, 0, 3);
        send(kcd_pkg::OP_QUERY, 0, 0, 1023);
        send(kcd_pkg::OP_COMPUTE, 0, 0, 0);
        send(kcd_pkg::OP_QUERY, 0, 0, 0);
        drain();

        for (int it = 0; it < 350; it++) begin
            quiet = (it > 300);
            pick = $urandom_range(0, 99);
            if (pick < 60 && sb.n_vert < 900 && sb.n_entry < 7000)
                add_vertex(($urandom_range(0, 30) == 0) ? $urandom_range(0, 1023)
                                                       : $urandom_range(0, 6));
            else if (pick < 80)
                send(kcd_pkg::OP_QUERY, $urandom, $urandom, ($urandom_range(0, 7) == 0)
                     ? $urandom_range(0, 1023) : $urandom_range(0, sb.n_vert));
            else if (pick < 88)
                send(kcd_pkg::OP_COMPUTE, $urandom, $urandom, $urandom);
            else if (pick < 94 && sb.n_entry < 7000)
                send(kcd_pkg::OP_LOAD_NB, $urandom, $urandom_range(0, 1023), $urandom);
            else if (sb.n_vert < 900)
                send(kcd_pkg::OP_LOAD_DEG, $urandom_range(0, 1023), $urandom, $urandom);
            if (it == 175) drain();
        end
        drain();

        // fill the vertex store, then overrun it
        quiet = 1'b1;
        while (sb.n_vert < kcd_pkg::MAX_VERTICES)
            send(kcd_pkg::OP_LOAD_DEG, $urandom_range(0, 4), $urandom, $urandom);
        send(kcd_pkg::OP_QUERY, 0, 0, 1023);
        send(kcd_pkg::OP_LOAD_DEG, 5, 0, 0);
        send(kcd_pkg::OP_QUERY, 0, 0, 0);
        send(kcd_pkg::OP_LOAD_NB, 0, 7, 0);
        send(kcd_pkg::OP_COMPUTE, 0, 0, 0);
        for (int k = 0; k < 20; k++)
            send(kcd_pkg::OP_QUERY, 0, 0, $urandom_range(0, 1023));

        start <= 1'b0;
        while (sb.pending_answers.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
